// ===== sv/svpwm_pkg.sv =====
// Shared types and constants for the seven-segment SVPWM compare unit.
// No dependencies.
package svpwm_pkg;

   // sqrt3 * 2^32, truncated
   localparam logic [32:0] SQRT3_Q32 = 33'd7439101573;

   localparam int PERIOD_W = 16;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;

   // register byte addresses
   localparam logic [2:0] ADDR_PWM_PERIOD = 3'd0;

   // sector codes: projection signs weighted 1, 2 and 4
   localparam logic [2:0] SEC_N1 = 3'd1;
   localparam logic [2:0] SEC_N2 = 3'd2;
   localparam logic [2:0] SEC_N3 = 3'd3;
   localparam logic [2:0] SEC_N4 = 3'd4;
   localparam logic [2:0] SEC_N5 = 3'd5;
   localparam logic [2:0] SEC_N6 = 3'd6;

   // what each phase holds in the seven-segment pattern
   typedef enum logic [1:0] {
      PH_ZERO = 2'd0,   // t0
      PH_T1   = 2'd1,   // t1 + t0
      PH_T2   = 2'd2,   // t2 + t0
      PH_FULL = 2'd3    // t1 + t2 + t0
   } phase_code_type;

   // pipeline control handed to the ratio divider
   typedef struct packed {
      logic                advance;
      logic [PERIOD_W-1:0] period;
   } pipe_ctl_type;

endpackage

// ===== sv/svpwm_seven_segment_compare_unit.sv =====
// Seven-segment SVPWM compare unit: sector, active times, compare values.
// Depends on svpwm_pkg, svpwm_qdiv and svpwm_rdiv.
// Pipeline from acceptance to rsp_valid: three front stages, FRAC_BITS + 34
// stages of active-time divider, one combine stage, 32 stages of
// overmodulation ratio unit, one output register.
// Throughput: one word per cycle; the whole pipe holds while a result waits.
// Reset: synchronous, clears all stage valid bits and sets the period to 4000.
module svpwm_seven_segment_compare_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_v_alpha,
   input  logic signed [15:0] req_v_beta,
   input  logic [15:0] req_bus_voltage,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_compare_a,
   output logic [15:0] rsp_compare_b,
   output logic [15:0] rsp_compare_c,
   output logic        rsp_overmodulated,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int F  = FRAC_BITS;
   localparam int PW = F + 19;          // signed projection width
   localparam int XW = F + 18;          // clamped projection
   localparam int NW = XW + 16;         // x * period and active times
   localparam int CW = NW + 2;
   localparam int DW = 17;
   localparam int CODES_W = 6;
   localparam int RSW = 3 * 16 + 1 + CODES_W;
   localparam logic [F:0] SQ = (F + 1)'(svpwm_pkg::SQRT3_Q32 >> (32 - F));

   localparam logic [2:0] REG_PERIOD = svpwm_pkg::ADDR_PWM_PERIOD;

   // ---------------- configuration ----------------
   logic [15:0] period_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svpwm_pkg::PERIOD_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_PERIOD[2])) begin
         period_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_PERIOD[2]) ? {16'd0, period_ff} : 32'd0;

   // ---------------- pipe control ----------------
   logic rsp_valid_ff;
   logic advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------- stage A: products ----------------
   logic                 a_vld_ff;
   logic signed [PW-1:0] a_sqvb_ff;
   logic signed [PW-1:0] a_va3_ff;
   logic [15:0]          a_vdc_ff;
   logic signed [F+17:0] sqvb_in;
   logic signed [17:0]   va3;

   always_comb begin
      sqvb_in = $signed({1'b0, SQ}) * req_v_beta;
      va3     = 18'(req_v_alpha) * 18'sd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_sqvb_ff <= PW'(sqvb_in);
         a_va3_ff  <= PW'(va3) <<< F;
         a_vdc_ff  <= req_bus_voltage;
      end
   end

   // ---------------- stage B: sector and selection ----------------
   logic                 b_vld_ff;
   logic [XW-1:0]        b_x1_ff;
   logic [XW-1:0]        b_x2_ff;
   logic [CODES_W-1:0]   b_codes_ff;
   logic [DW-1:0]        b_den_ff;
   logic signed [PW-1:0] pa, pb, pc, sel1, sel2;
   logic [2:0]           sector;
   svpwm_pkg::phase_code_type ca, cb, cc;
   logic [XW-1:0]        x1_in, x2_in;
   logic [DW-1:0]        den_in;

   always_comb begin
      pa = a_sqvb_ff <<< 1;
      pb = a_va3_ff - a_sqvb_ff;
      pc = -a_va3_ff - a_sqvb_ff;
      sector = {pc > 0, pb > 0, pa > 0};
      sel1 = '0;
      sel2 = '0;
      ca = svpwm_pkg::PH_ZERO;
      cb = svpwm_pkg::PH_ZERO;
      cc = svpwm_pkg::PH_ZERO;
      unique case (sector)
         svpwm_pkg::SEC_N3: begin
            sel1 = pb;  sel2 = pa;
            ca = svpwm_pkg::PH_FULL; cb = svpwm_pkg::PH_T2;
         end
         svpwm_pkg::SEC_N1: begin
            sel1 = -pc; sel2 = -pb;
            ca = svpwm_pkg::PH_T1; cb = svpwm_pkg::PH_FULL;
         end
         svpwm_pkg::SEC_N5: begin
            sel1 = pa;  sel2 = pc;
            cb = svpwm_pkg::PH_FULL; cc = svpwm_pkg::PH_T2;
         end
         svpwm_pkg::SEC_N4: begin
            sel1 = -pb; sel2 = -pa;
            cb = svpwm_pkg::PH_T1; cc = svpwm_pkg::PH_FULL;
         end
         svpwm_pkg::SEC_N6: begin
            sel1 = pc;  sel2 = pb;
            ca = svpwm_pkg::PH_T2; cc = svpwm_pkg::PH_FULL;
         end
         svpwm_pkg::SEC_N2: begin
            sel1 = -pa; sel2 = -pc;
            ca = svpwm_pkg::PH_FULL; cc = svpwm_pkg::PH_T1;
         end
         default: begin
            // zero vector and the impossible sector: all phases at T/2
         end
      endcase
      x1_in  = sel1[PW-1] ? '0 : sel1[XW-1:0];
      x2_in  = sel2[PW-1] ? '0 : sel2[XW-1:0];
      den_in = (a_vdc_ff == 16'd0) ? DW'(2) : {a_vdc_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (advance) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_x1_ff    <= x1_in;
         b_x2_ff    <= x2_in;
         b_codes_ff <= {ca, cb, cc};
         b_den_ff   <= den_in;
      end
   end

   // ---------------- stage C: scale by period ----------------
   logic               c_vld_ff;
   logic [NW-1:0]      c_n1_ff;
   logic [NW-1:0]      c_n2_ff;
   logic [CODES_W-1:0] c_codes_ff;
   logic [DW-1:0]      c_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (advance) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_n1_ff    <= NW'(b_x1_ff) * NW'(period_ff);
         c_n2_ff    <= NW'(b_x2_ff) * NW'(period_ff);
         c_codes_ff <= b_codes_ff;
         c_den_ff   <= b_den_ff;
      end
   end

   // ---------------- active-time divider ----------------
   logic               q_vld;
   logic [NW-1:0]      t1, t2;
   logic [CODES_W-1:0] q_codes;

   svpwm_qdiv #(.NW(NW), .DW(DW), .SW(CODES_W)) u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_vld   (c_vld_ff),
      .num_a    (c_n1_ff),
      .num_b    (c_n2_ff),
      .den      (c_den_ff),
      .side_in  (c_codes_ff),
      .out_vld  (q_vld),
      .quo_a    (t1),
      .quo_b    (t2),
      .side_out (q_codes)
   );

   // ---------------- stage D: normal compares, overmodulation test ----------------
   function automatic logic [15:0] normal_cmp(input logic [1:0] code,
                                              input logic [CW-1:0] tq,
                                              input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
      logic [CW-1:0] num;
      unique case (svpwm_pkg::phase_code_type'(code))
         svpwm_pkg::PH_FULL: num = tq + a + b;
         svpwm_pkg::PH_T1:   num = tq + a - b;
         svpwm_pkg::PH_T2:   num = tq + b - a;
         default:            num = tq - a - b;
      endcase
      normal_cmp = num[F+16:F+1];
   endfunction

   logic               d_vld_ff;
   logic [NW-1:0]      d_x_ff;
   logic [NW:0]        d_sum_ff;
   logic [RSW-1:0]     d_side_ff;
   logic [CW-1:0]      tq_w, t1_w, t2_w;
   logic [NW:0]        sum_in;
   logic               over_in;
   logic               mid_t1;

   always_comb begin
      tq_w    = CW'({period_ff, F'(0)});
      t1_w    = CW'(t1);
      t2_w    = CW'(t2);
      sum_in  = (NW + 1)'(t1) + (NW + 1)'(t2);
      over_in = (CW'(sum_in) > tq_w);
      mid_t1  = (q_codes[5:4] == svpwm_pkg::PH_T1) || (q_codes[3:2] == svpwm_pkg::PH_T1)
             || (q_codes[1:0] == svpwm_pkg::PH_T1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (advance) begin
         d_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_x_ff    <= mid_t1 ? t1 : t2;
         d_sum_ff  <= sum_in;
         d_side_ff <= {normal_cmp(q_codes[5:4], tq_w, t1_w, t2_w),
                       normal_cmp(q_codes[3:2], tq_w, t1_w, t2_w),
                       normal_cmp(q_codes[1:0], tq_w, t1_w, t2_w),
                       over_in, q_codes};
      end
   end

   // ---------------- overmodulation ratio ----------------
   svpwm_pkg::pipe_ctl_type rctl;
   logic                    r_vld;
   logic [15:0]             r_quo;
   logic [RSW-1:0]          r_side;

   assign rctl.advance = advance;
   assign rctl.period  = period_ff;

   svpwm_rdiv #(.NW(NW), .SW(RSW)) u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (rctl),
      .in_vld   (d_vld_ff),
      .x_in     (d_x_ff),
      .s_in     (d_sum_ff),
      .side_in  (d_side_ff),
      .out_vld  (r_vld),
      .quo      (r_quo),
      .side_out (r_side)
   );

   // ---------------- stage E: output register ----------------
   function automatic logic [15:0] over_cmp(input logic [1:0] code,
                                            input logic [15:0] per,
                                            input logic [15:0] ratio);
      unique case (svpwm_pkg::phase_code_type'(code))
         svpwm_pkg::PH_FULL: over_cmp = per;
         svpwm_pkg::PH_T1:   over_cmp = ratio;
         svpwm_pkg::PH_T2:   over_cmp = ratio;
         default:            over_cmp = 16'd0;
      endcase
   endfunction

   logic [15:0] cmp_a_ff, cmp_b_ff, cmp_c_ff;
   logic        over_ff;
   logic        r_over;

   assign r_over = r_side[CODES_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= r_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         over_ff  <= r_over;
         cmp_a_ff <= r_over ? over_cmp(r_side[5:4], period_ff, r_quo) : r_side[RSW-1:RSW-16];
         cmp_b_ff <= r_over ? over_cmp(r_side[3:2], period_ff, r_quo)
                            : r_side[RSW-17:RSW-32];
         cmp_c_ff <= r_over ? over_cmp(r_side[1:0], period_ff, r_quo)
                            : r_side[RSW-33:RSW-48];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_a     = cmp_a_ff;
   assign rsp_compare_b     = cmp_b_ff;
   assign rsp_compare_c     = cmp_c_ff;
   assign rsp_overmodulated = over_ff;

   // ---------------- checks ----------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("output word valid straight after reset");

   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cmp_a_ff <= period_ff) && (cmp_b_ff <= period_ff)
                       && (cmp_c_ff <= period_ff))
      else $error("compare value above period");

   a_over_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && over_ff |->
         (cmp_a_ff == period_ff) || (cmp_b_ff == period_ff) || (cmp_c_ff == period_ff))
      else $error("overmodulated word without a full phase");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cmp_a_ff) && $stable(d_sum_ff) && $stable(c_n1_ff))
      else $error("pipe moved while stalled");

endmodule

// ===== sv/svpwm_qdiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared divisor with a sideband word carried alongside. No package use.
module svpwm_qdiv #(
   parameter int NW = 50,
   parameter int DW = 17,
   parameter int SW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_vld,
   input  logic [NW-1:0] num_a,
   input  logic [NW-1:0] num_b,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_vld,
   output logic [NW-1:0] quo_a,
   output logic [NW-1:0] quo_b,
   output logic [SW-1:0] side_out
);

   logic [NW-1:0] vld_ff;
   logic [NW-1:0] na_ff  [NW];
   logic [NW-1:0] nb_ff  [NW];
   logic [DW-1:0] ra_ff  [NW];
   logic [DW-1:0] rb_ff  [NW];
   logic [DW-1:0] den_ff [NW];
   logic [SW-1:0] side_ff[NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          v_src;
      logic [NW-1:0] na_src;
      logic [NW-1:0] nb_src;
      logic [DW-1:0] ra_src;
      logic [DW-1:0] rb_src;
      logic [DW-1:0] d_src;
      logic [SW-1:0] s_src;
      logic [DW:0]   ta;
      logic [DW:0]   tb;
      logic [DW:0]   da;
      logic [DW:0]   db;
      logic          qa;
      logic          qb;

      if (k == 0) begin : g_head
         assign v_src  = in_vld;
         assign na_src = num_a;
         assign nb_src = num_b;
         assign ra_src = '0;
         assign rb_src = '0;
         assign d_src  = den;
         assign s_src  = side_in;
      end else begin : g_body
         assign v_src  = vld_ff[k-1];
         assign na_src = na_ff[k-1];
         assign nb_src = nb_ff[k-1];
         assign ra_src = ra_ff[k-1];
         assign rb_src = rb_ff[k-1];
         assign d_src  = den_ff[k-1];
         assign s_src  = side_ff[k-1];
      end

      always_comb begin
         ta = {ra_src, na_src[NW-1]};
         tb = {rb_src, nb_src[NW-1]};
         qa = (ta >= {1'b0, d_src});
         qb = (tb >= {1'b0, d_src});
         da = ta - {1'b0, d_src};
         db = tb - {1'b0, d_src};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= v_src;
         end
      end

      // numerator bits shift out at the top, quotient bits come in below
      always_ff @(posedge clock) begin
         if (advance) begin
            na_ff[k]   <= {na_src[NW-2:0], qa};
            nb_ff[k]   <= {nb_src[NW-2:0], qb};
            ra_ff[k]   <= qa ? da[DW-1:0] : ta[DW-1:0];
            rb_ff[k]   <= qb ? db[DW-1:0] : tb[DW-1:0];
            den_ff[k]  <= d_src;
            side_ff[k] <= s_src;
         end
      end
   end

   assign out_vld  = vld_ff[NW-1];
   assign quo_a    = na_ff[NW-1];
   assign quo_b    = nb_ff[NW-1];
   assign side_out = side_ff[NW-1];

endmodule

// ===== sv/svpwm_rdiv.sv =====
// Pipelined ratio unit: floor(x * period / s) for x <= s, two half-steps per
// period bit, one per stage. Uses svpwm_pkg for the control struct.
module svpwm_rdiv #(
   parameter int NW = 50,
   parameter int SW = 55
) (
   input  logic                    clock,
   input  logic                    reset,
   input  svpwm_pkg::pipe_ctl_type ctl,
   input  logic                    in_vld,
   input  logic [NW-1:0]           x_in,
   input  logic [NW:0]             s_in,
   input  logic [SW-1:0]           side_in,
   output logic                    out_vld,
   output logic [svpwm_pkg::PERIOD_W-1:0] quo,
   output logic [SW-1:0]           side_out
);

   localparam int PW = svpwm_pkg::PERIOD_W;
   localparam int NS = 2 * PW;
   localparam int RW = NW + 2;

   logic [NS-1:0] vld_ff;
   logic [PW-1:0] q_ff   [NS];
   logic [RW-1:0] r_ff   [NS];
   logic [RW-1:0] s_ff   [NS];
   logic [NW-1:0] x_ff   [NS];
   logic [SW-1:0] side_ff[NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam int B = PW - 1 - (k / 2);
      logic          v_src;
      logic [PW-1:0] q_src;
      logic [RW-1:0] r_src;
      logic [RW-1:0] s_src;
      logic [NW-1:0] x_src;
      logic [SW-1:0] sd_src;
      logic [PW-1:0] q1;
      logic [RW-1:0] r2;
      logic          take;
      logic [PW-1:0] q_in;
      logic [RW-1:0] r_in;

      if (k == 0) begin : g_head
         assign v_src  = in_vld;
         assign q_src  = '0;
         assign r_src  = '0;
         assign s_src  = {1'b0, s_in};
         assign x_src  = x_in;
         assign sd_src = side_in;
      end else begin : g_body
         assign v_src  = vld_ff[k-1];
         assign q_src  = q_ff[k-1];
         assign r_src  = r_ff[k-1];
         assign s_src  = s_ff[k-1];
         assign x_src  = x_ff[k-1];
         assign sd_src = side_ff[k-1];
      end

      if ((k % 2) == 0) begin : g_dbl
         // shift step: q <<= 1, r <<= 1, reduce
         always_comb begin
            q1   = {q_src[PW-2:0], 1'b0};
            r2   = {r_src[RW-2:0], 1'b0};
            take = (r2 >= s_src);
         end
      end else begin : g_add
         // add step: fold in x where this period bit is set
         always_comb begin
            q1   = q_src;
            r2   = ctl.period[B] ? r_src + RW'(x_src) : r_src;
            take = ctl.period[B] && (r2 >= s_src);
         end
      end

      always_comb begin
         q_in = take ? q1 + PW'(1) : q1;
         r_in = take ? r2 - s_src : r2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            q_ff[k]    <= q_in;
            r_ff[k]    <= r_in;
            s_ff[k]    <= s_src;
            x_ff[k]    <= x_src;
            side_ff[k] <= sd_src;
         end
      end
   end

   assign out_vld  = vld_ff[NS-1];
   assign quo      = q_ff[NS-1];
   assign side_out = side_ff[NS-1];

endmodule
